>>> hw/rtl/front_middle_back_queue_unit_macros.svh
// assertion macros for the front/middle/back queue unit checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef FRONT_MIDDLE_BACK_QUEUE_UNIT_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_UNIT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define FMBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that is also checked through reset
`define FMBQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fmbq_pkg.sv
// shared types, constants and index helpers for the front/middle/back queue
// no dependencies; used by fmbq_ctrl, the top level and the checker
package fmbq_pkg;

  localparam int HALF_DEPTH = 512;
  localparam int VALUE_W    = 32;
  localparam int KIND_W     = 3;
  localparam int IDX_W      = $clog2(HALF_DEPTH);
  localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
  localparam int TOT_W      = CNT_W + 1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TOT_W-1:0]   tot_t;
  typedef logic [VALUE_W-1:0] val_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT  = 3'd0,
    KIND_PUSH_MIDDLE = 3'd1,
    KIND_PUSH_BACK   = 3'd2,
    KIND_POP_FRONT   = 3'd3,
    KIND_POP_MIDDLE  = 3'd4,
    KIND_POP_BACK    = 3'd5
  } kind_t;

  // write data source: the request value or the other half's read data
  typedef enum logic {
    SRC_VALUE,
    SRC_PEER
  } src_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_FRONT,
    RES_BACK
  } res_sel_t;

  // what one half's memory does for a request
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    logic wr_en;
    idx_t wr_addr;
    src_t wr_src;
  } port_plan_t;

  // decoded request: memory accesses, result and next pointers
  typedef struct packed {
    port_plan_t f;
    port_plan_t b;
    res_sel_t   res_sel;
    logic       was_empty;
    logic       was_full;
    idx_t       fh;
    cnt_t       fc;
    idx_t       bh;
    cnt_t       bc;
  } plan_t;

  // one port of a half memory
  typedef struct packed {
    logic en;
    logic we;
    idx_t addr;
    val_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    val_t value;
    logic was_empty;
    logic was_full;
  } result_t;

  // circular index helpers
  function automatic idx_t idx_inc(input idx_t i);
    return (i == idx_t'(HALF_DEPTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t idx_dec(input idx_t i);
    return (i == '0) ? idx_t'(HALF_DEPTH - 1) : i - idx_t'(1);
  endfunction

  function automatic idx_t idx_add(input idx_t h, input cnt_t c);
    tot_t s;
    s = tot_t'(h) + tot_t'(c);
    if (s >= tot_t'(HALF_DEPTH)) begin
      s = s - tot_t'(HALF_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/fmbq_ram.sv
// generic single-port synchronous ram with registered read data
// read data register holds its value until the next read; no dependencies
module fmbq_ram #(
  parameter int DEPTH  = 512,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one access per cycle, write or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fmbq_ctrl.sv
// request decoder and read/write-back sequencer for the two queue halves
// depends on fmbq_pkg; drives the two half memories instantiated at the top
module fmbq_ctrl import fmbq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [KIND_W-1:0] req_kind,
  input  val_t              req_value,
  output mem_req_t          f_req,
  input  val_t              f_rdata,
  output mem_req_t          b_req,
  input  val_t              b_rdata,
  output result_t           res,
  input  logic              res_ready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  state_t state_r, state_nxt;
  plan_t  plan_r, plan_nxt;
  val_t   value_r;
  idx_t   fh_r, bh_r;
  cnt_t   fc_r, bc_r;

  idx_t  ft, flast, bt, blast, fh_dec, fh_inc, bh_dec, bh_inc;
  tot_t  total;
  logic  is_full, is_empty, f_gt, f_eq;
  logic  accept, commit;

  // pointer arithmetic on the current state
  always_comb begin
    ft       = idx_add(fh_r, fc_r);
    flast    = idx_dec(ft);
    bt       = idx_add(bh_r, bc_r);
    blast    = idx_dec(bt);
    fh_dec   = idx_dec(fh_r);
    fh_inc   = idx_inc(fh_r);
    bh_dec   = idx_dec(bh_r);
    bh_inc   = idx_inc(bh_r);
    total    = tot_t'(fc_r) + tot_t'(bc_r);
    is_full  = (total == tot_t'(2 * HALF_DEPTH));
    is_empty = (total == '0);
    f_gt     = (fc_r > bc_r);
    f_eq     = (fc_r == bc_r);
  end

  // decode a request into memory accesses and new pointers
  always_comb begin
    plan_nxt         = '0;
    plan_nxt.f.wr_src = SRC_VALUE;
    plan_nxt.b.wr_src = SRC_VALUE;
    plan_nxt.res_sel = RES_NONE;
    plan_nxt.fh      = fh_r;
    plan_nxt.fc      = fc_r;
    plan_nxt.bh      = bh_r;
    plan_nxt.bc      = bc_r;
    case (kind_t'(req_kind))
      KIND_PUSH_FRONT: begin
        if (is_full) begin
          plan_nxt.was_full = 1'b1;
        end else begin
          plan_nxt.f.wr_en   = 1'b1;
          plan_nxt.f.wr_addr = fh_dec;
          plan_nxt.fh        = fh_dec;
          if (f_gt) begin
            // front tail moves over to the back head first
            plan_nxt.f.rd_en   = 1'b1;
            plan_nxt.f.rd_addr = flast;
            plan_nxt.b.wr_en   = 1'b1;
            plan_nxt.b.wr_addr = bh_dec;
            plan_nxt.b.wr_src  = SRC_PEER;
            plan_nxt.bh        = bh_dec;
            plan_nxt.bc        = bc_r + cnt_t'(1);
          end else begin
            plan_nxt.fc = fc_r + cnt_t'(1);
          end
        end
      end
      KIND_PUSH_MIDDLE: begin
        if (is_full) begin
          plan_nxt.was_full = 1'b1;
        end else if (f_gt) begin
          // front tail moves to the back head, new value takes its slot
          plan_nxt.f.rd_en   = 1'b1;
          plan_nxt.f.rd_addr = flast;
          plan_nxt.f.wr_en   = 1'b1;
          plan_nxt.f.wr_addr = flast;
          plan_nxt.b.wr_en   = 1'b1;
          plan_nxt.b.wr_addr = bh_dec;
          plan_nxt.b.wr_src  = SRC_PEER;
          plan_nxt.bh        = bh_dec;
          plan_nxt.bc        = bc_r + cnt_t'(1);
        end else begin
          plan_nxt.f.wr_en   = 1'b1;
          plan_nxt.f.wr_addr = ft;
          plan_nxt.fc        = fc_r + cnt_t'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (is_full) begin
          plan_nxt.was_full = 1'b1;
        end else if (!f_eq) begin
          plan_nxt.b.wr_en   = 1'b1;
          plan_nxt.b.wr_addr = bt;
          plan_nxt.bc        = bc_r + cnt_t'(1);
        end else if (bc_r == '0) begin
          // both halves empty: the value lands straight in the front half
          plan_nxt.f.wr_en   = 1'b1;
          plan_nxt.f.wr_addr = ft;
          plan_nxt.fc        = fc_r + cnt_t'(1);
        end else begin
          // back head moves to the front tail, value goes to the back tail
          plan_nxt.b.rd_en   = 1'b1;
          plan_nxt.b.rd_addr = bh_r;
          plan_nxt.b.wr_en   = 1'b1;
          plan_nxt.b.wr_addr = bt;
          plan_nxt.f.wr_en   = 1'b1;
          plan_nxt.f.wr_addr = ft;
          plan_nxt.f.wr_src  = SRC_PEER;
          plan_nxt.bh        = bh_inc;
          plan_nxt.fc        = fc_r + cnt_t'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (is_empty) begin
          plan_nxt.was_empty = 1'b1;
        end else begin
          plan_nxt.f.rd_en   = 1'b1;
          plan_nxt.f.rd_addr = fh_r;
          plan_nxt.res_sel   = RES_FRONT;
          plan_nxt.fh        = fh_inc;
          if (f_eq) begin
            plan_nxt.b.rd_en   = 1'b1;
            plan_nxt.b.rd_addr = bh_r;
            plan_nxt.f.wr_en   = 1'b1;
            plan_nxt.f.wr_addr = ft;
            plan_nxt.f.wr_src  = SRC_PEER;
            plan_nxt.bh        = bh_inc;
            plan_nxt.bc        = bc_r - cnt_t'(1);
          end else begin
            plan_nxt.fc = fc_r - cnt_t'(1);
          end
        end
      end
      KIND_POP_MIDDLE: begin
        if (is_empty) begin
          plan_nxt.was_empty = 1'b1;
        end else begin
          plan_nxt.f.rd_en   = 1'b1;
          plan_nxt.f.rd_addr = flast;
          plan_nxt.res_sel   = RES_FRONT;
          if (f_eq) begin
            // back head refills the slot just emptied
            plan_nxt.b.rd_en   = 1'b1;
            plan_nxt.b.rd_addr = bh_r;
            plan_nxt.f.wr_en   = 1'b1;
            plan_nxt.f.wr_addr = flast;
            plan_nxt.f.wr_src  = SRC_PEER;
            plan_nxt.bh        = bh_inc;
            plan_nxt.bc        = bc_r - cnt_t'(1);
          end else begin
            plan_nxt.fc = fc_r - cnt_t'(1);
          end
        end
      end
      KIND_POP_BACK: begin
        if (is_empty) begin
          plan_nxt.was_empty = 1'b1;
        end else if (bc_r == '0) begin
          // single item, held in the front half
          plan_nxt.f.rd_en   = 1'b1;
          plan_nxt.f.rd_addr = flast;
          plan_nxt.res_sel   = RES_FRONT;
          plan_nxt.fc        = fc_r - cnt_t'(1);
        end else begin
          plan_nxt.b.rd_en   = 1'b1;
          plan_nxt.b.rd_addr = blast;
          plan_nxt.res_sel   = RES_BACK;
          if (f_gt) begin
            plan_nxt.f.rd_en   = 1'b1;
            plan_nxt.f.rd_addr = flast;
            plan_nxt.b.wr_en   = 1'b1;
            plan_nxt.b.wr_addr = bh_dec;
            plan_nxt.b.wr_src  = SRC_PEER;
            plan_nxt.bh        = bh_dec;
            plan_nxt.fc        = fc_r - cnt_t'(1);
          end else begin
            plan_nxt.bc = bc_r - cnt_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: accept, read the halves the plan names, write back and report
  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (state_r == ST_WRITE) && res_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fh_r    <= '0;
      fc_r    <= '0;
      bh_r    <= '0;
      bc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        plan_r  <= plan_nxt;
        value_r <= req_value;
      end
      if (commit) begin
        fh_r <= plan_r.fh;
        fc_r <= plan_r.fc;
        bh_r <= plan_r.bh;
        bc_r <= plan_r.bc;
      end
    end
  end

  // memory ports: reads in the read cycle, writes once the result can leave
  always_comb begin
    f_req = '0;
    b_req = '0;
    case (state_r)
      ST_READ: begin
        f_req.en   = plan_r.f.rd_en;
        f_req.addr = plan_r.f.rd_addr;
        b_req.en   = plan_r.b.rd_en;
        b_req.addr = plan_r.b.rd_addr;
      end
      ST_WRITE: begin
        f_req.en    = plan_r.f.wr_en && res_ready;
        f_req.we    = 1'b1;
        f_req.addr  = plan_r.f.wr_addr;
        f_req.wdata = (plan_r.f.wr_src == SRC_PEER) ? b_rdata : value_r;
        b_req.en    = plan_r.b.wr_en && res_ready;
        b_req.we    = 1'b1;
        b_req.addr  = plan_r.b.wr_addr;
        b_req.wdata = (plan_r.b.wr_src == SRC_PEER) ? f_rdata : value_r;
      end
      default: begin
      end
    endcase
  end

  // result of the request in flight
  always_comb begin
    res.valid     = (state_r == ST_WRITE);
    res.was_empty = plan_r.was_empty;
    res.was_full  = plan_r.was_full;
    case (plan_r.res_sel)
      RES_FRONT: res.value = f_rdata;
      RES_BACK:  res.value = b_rdata;
      default:   res.value = '1;
    endcase
  end

endmodule

>>> hw/rtl/front_middle_back_queue_unit.sv
// Front/middle/back queue: takes push and pop requests at the front, the middle and the
// back of one queue of up to 2*HALF_DEPTH (1024) values, kept as two circular halves in
// two single-port memories. Each request passes through accept, memory read and write back,
// and one request is worked on at a time; the read-then-write order on the half memories
// sets that sequence. The result sits in an output register, so a finished result waiting on
// out_tready does not hold the next request back until its write-back. A pop of an empty
// queue returns -1 with was_empty set; a push to a full queue is dropped and returns -1
// with was_full set; pushes and unused kinds return -1.
// depends on fmbq_pkg, fmbq_ctrl and fmbq_ram
module front_middle_back_queue_unit import fmbq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic [KIND_W-1:0]  in_tuser,   // [2:0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [31:0] result_value
  output logic [1:0]         out_tuser   // [0] was_empty, [1] was_full
);

  mem_req_t f_req, b_req;
  val_t     f_rdata, b_rdata;
  result_t  res;
  logic     res_ready;

  logic     out_valid_r, out_valid_nxt;
  val_t     out_data_r;
  logic [1:0] out_user_r;

  fmbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser),
    .req_value (in_tdata),
    .f_req     (f_req),
    .f_rdata   (f_rdata),
    .b_req     (b_req),
    .b_rdata   (b_rdata),
    .res       (res),
    .res_ready (res_ready)
  );

  // front half store
  fmbq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (VALUE_W)
  ) u_front_ram (
    .clk   (clk),
    .en    (f_req.en),
    .we    (f_req.we),
    .addr  (f_req.addr),
    .wdata (f_req.wdata),
    .rdata (f_rdata)
  );

  // back half store
  fmbq_ram #(
    .DEPTH (HALF_DEPTH),
    .WIDTH (VALUE_W)
  ) u_back_ram (
    .clk   (clk),
    .en    (b_req.en),
    .we    (b_req.we),
    .addr  (b_req.addr),
    .wdata (b_req.wdata),
    .rdata (b_rdata)
  );

  // output register, refilled as the previous result is taken
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (res.valid && res_ready) begin
        out_data_r <= res.value;
        out_user_r <= {res.was_full, res.was_empty};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> hw/rtl/fmbq_checker.sv
// port-level checker for front_middle_back_queue_unit, attached by bind
// depends on fmbq_pkg and front_middle_back_queue_unit_macros.svh
`include "front_middle_back_queue_unit_macros.svh"

module fmbq_checker import fmbq_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [VALUE_W-1:0] out_tdata,
  input logic [1:0]         out_tuser
);

  // one request at a time: no new request while it reads and writes back
  `FMBQ_ASSERT(a_busy_after_accept,
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready,
    "request accepted while busy")

  // a fresh result comes from an earlier accepted request
  `FMBQ_ASSERT(a_result_from_request,
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 3),
    "result without a request")

  // flagged results carry -1 and never both flags
  `FMBQ_ASSERT(a_flag_value,
    (out_tvalid && (out_tuser[0] || out_tuser[1])) |->
      ((out_tdata == '1) && !(out_tuser[0] && out_tuser[1])),
    "bad flagged result")

  // stalled result holds
  `FMBQ_ASSERT(a_out_hold,
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)),
    "stalled result changed")

  // reset empties the output register
  `FMBQ_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind front_middle_back_queue_unit fmbq_checker u_fmbq_checker (.*);
